[design/ldpc_bf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldpc_bf_pkg
// Shared constants and controller/datapath command types for the decoder.
// ----------------------------------------------------------------------------
package ldpc_bf_pkg;

    // iteration count / flip count width
    localparam int ITER_W = 6;
    localparam logic [ITER_W-1:0] ITER_RESET = 6'd10;

    // configuration register indexes
    localparam logic CFG_MATRIX = 1'b0;
    localparam logic CFG_ITER   = 1'b1;

    typedef struct packed {
        logic              load;     // take a new received word
        logic              flip;     // flip the selected bit
        logic              capture;  // write the result into the output register
        logic              ok;       // result status for capture
        logic [ITER_W-1:0] flips;    // flips done so far
    } ldpc_bf_cmd_t;

    typedef struct packed {
        logic syn_zero;              // all checks hold for the current word
    } ldpc_bf_status_t;

endpackage
`default_nettype wire

[design/ldpc_bf_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldpc_bf_in_if / ldpc_bf_out_if
// Valid/ready channels for received words and decode results.
// ----------------------------------------------------------------------------
interface ldpc_bf_in_if #(
    parameter int WORD_W = 6
);
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] received_word;

    modport source (output valid, output received_word, input ready);
    modport sink   (input valid, input received_word, output ready);
endinterface

interface ldpc_bf_out_if #(
    parameter int WORD_W = 6,
    parameter int CNT_W  = 6
);
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] decoded_word;
    logic              decode_ok;
    logic [CNT_W-1:0]  flips_done;

    modport source (output valid, output decoded_word, output decode_ok,
                    output flips_done, input ready);
    modport sink   (input valid, input decoded_word, input decode_ok,
                    input flips_done, output ready);
endinterface
`default_nettype wire

[design/ldpc_bit_flip_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldpc_bit_flip_decoder
// Hard-decision bit-flipping decoder for one short codeword per word.
//
// din carries received_word; dout carries decoded_word, decode_ok and
// flips_done, one result per input. Both use valid/ready, a word moves
// when both are high. cfg_we/cfg_index/cfg_data write the check matrix
// (index 0) and the iteration budget (index 1); write only while idle.
// After a word is accepted the sequencer runs one check-and-flip
// iteration per cycle, flipping one bit each time, until all checks
// hold or the flip count reaches the iteration budget (default 10).
// A single iteration unit serves; one word is decoded at a time.
// Results sit in an output register, so a new word is accepted while
// the previous result still waits. If the receiver stalls and the
// register is full, the finished word holds in the decoder until it
// frees. Reset clears the handshake state and loads the default matrix
// and an iteration budget of 10.
// ----------------------------------------------------------------------------
module ldpc_bit_flip_decoder
    import ldpc_bf_pkg::*;
#(
    parameter int CHECK_ROWS    = 3,
    parameter int CODE_BITS     = 6,
    parameter int MATRIX_RESET  = 211357
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ldpc_bf_in_if.sink                 din,
    ldpc_bf_out_if.source              dout,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [((CHECK_ROWS*CODE_BITS > ITER_W) ?
                        CHECK_ROWS*CODE_BITS : ITER_W)-1:0] cfg_data
);

    localparam int MAT_W = CHECK_ROWS * CODE_BITS;

    logic [MAT_W-1:0]  matrix_reg;
    logic [ITER_W-1:0] max_iter_reg;
    ldpc_bf_cmd_t      cmd;
    ldpc_bf_status_t   status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_reg   <= MAT_W'(MATRIX_RESET);
            max_iter_reg <= ITER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MATRIX: matrix_reg   <= cfg_data[MAT_W-1:0];
                CFG_ITER:   max_iter_reg <= cfg_data[ITER_W-1:0];
                default:    ;
            endcase
        end
    end

    ldpc_bf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (din.valid),
        .in_ready  (din.ready),
        .out_ready (dout.ready),
        .out_valid (dout.valid),
        .max_iter  (max_iter_reg),
        .status    (status),
        .cmd       (cmd)
    );

    ldpc_bf_dp #(
        .CHECK_ROWS (CHECK_ROWS),
        .CODE_BITS  (CODE_BITS)
    ) u_dp (
        .clk       (clk),
        .matrix    (matrix_reg),
        .in_word   (din.received_word),
        .cmd       (cmd),
        .status    (status),
        .res_word  (dout.decoded_word),
        .res_ok    (dout.decode_ok),
        .res_flips (dout.flips_done)
    );

    // result register is never overwritten while a word is still pending
    a_capture_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (!dout.valid || dout.ready))
        else $error("result captured over an untaken word");

    a_capture_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> dout.valid)
        else $error("captured result not presented");

    // flip count stays within the budget while decoding
    a_flip_budget: assert property (@(posedge clk) disable iff (!rst_n)
        !din.ready |-> (cmd.flips <= max_iter_reg))
        else $error("flip count beyond iteration budget");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (din.valid && din.ready) |=> !din.ready)
        else $error("second word accepted while decoding");

endmodule
`default_nettype wire

[design/ldpc_bf_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldpc_bf_ctrl
// Sequencer: accepts a word, runs one check-and-flip iteration per cycle,
// and hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module ldpc_bf_ctrl
    import ldpc_bf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              out_ready,
    output logic                   out_valid,
    input  wire logic [ITER_W-1:0] max_iter,
    input  wire ldpc_bf_status_t   status,
    output ldpc_bf_cmd_t           cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              ok_reg, ok_next;
    logic              out_valid_reg, out_valid_next;
    logic              slot_free;
    logic              iter_out;

    assign slot_free = !out_valid_reg || out_ready;
    assign iter_out  = (iter_reg == max_iter);
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        iter_next   = iter_reg;
        ok_next     = ok_reg;
        cmd.load    = 1'b0;
        cmd.flip    = 1'b0;
        cmd.capture = 1'b0;
        cmd.ok      = ok_reg;
        cmd.flips   = iter_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    iter_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (iter_out || status.syn_zero)
                begin
                    // success only if checks pass before the budget is spent
                    ok_next = !iter_out && status.syn_zero;
                    cmd.ok  = ok_next;
                    if (slot_free)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
                else
                begin
                    cmd.flip  = 1'b1;
                    iter_next = iter_reg + 1'b1;
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.capture)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

[design/ldpc_bf_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldpc_bf_dp
// Word register, syndrome, per-bit failed-check counts, argmax select,
// bit flip and the output result register.
// ----------------------------------------------------------------------------
module ldpc_bf_dp
    import ldpc_bf_pkg::*;
#(
    parameter int CHECK_ROWS = 3,
    parameter int CODE_BITS  = 6
)(
    input  wire logic                            clk,
    input  wire logic [CHECK_ROWS*CODE_BITS-1:0] matrix,
    input  wire logic [CODE_BITS-1:0]            in_word,
    input  wire ldpc_bf_cmd_t                    cmd,
    output ldpc_bf_status_t                      status,
    output logic [CODE_BITS-1:0]                 res_word,
    output logic                                 res_ok,
    output logic [ITER_W-1:0]                    res_flips
);

    localparam int CNT_W = $clog2(CHECK_ROWS + 1);
    localparam int IDX_W = $clog2(CODE_BITS);

    logic [CODE_BITS-1:0]  word_reg;
    logic [CODE_BITS-1:0]  res_word_reg;
    logic                  res_ok_reg;
    logic [ITER_W-1:0]     res_flips_reg;
    logic [CHECK_ROWS-1:0] syn;
    logic [CNT_W-1:0]      count [CODE_BITS];
    logic [CNT_W-1:0]      best_cnt;
    logic [IDX_W-1:0]      best_idx;
    logic [CODE_BITS-1:0]  flip_mask;

    always_comb
    begin
        for (int r = 0; r < CHECK_ROWS; r++)
            syn[r] = ^(matrix[r*CODE_BITS +: CODE_BITS] & word_reg);
    end

    assign status.syn_zero = (syn == '0);

    // failed checks touching each bit
    always_comb
    begin
        for (int c = 0; c < CODE_BITS; c++)
        begin
            count[c] = '0;
            for (int r = 0; r < CHECK_ROWS; r++)
                count[c] = count[c] + CNT_W'(syn[r] & matrix[r*CODE_BITS + c]);
        end
    end

    // strict compare keeps the lowest index on ties
    always_comb
    begin
        best_cnt = count[0];
        best_idx = '0;
        for (int c = 1; c < CODE_BITS; c++)
        begin
            if (count[c] > best_cnt)
            begin
                best_cnt = count[c];
                best_idx = IDX_W'(c);
            end
        end
    end

    always_comb
    begin
        flip_mask = '0;
        flip_mask[best_idx] = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            word_reg <= in_word;
        else if (cmd.flip)
            word_reg <= word_reg ^ flip_mask;
        if (cmd.capture)
        begin
            res_word_reg  <= word_reg;
            res_ok_reg    <= cmd.ok;
            res_flips_reg <= cmd.flips;
        end
    end

    assign res_word  = res_word_reg;
    assign res_ok    = res_ok_reg;
    assign res_flips = res_flips_reg;

endmodule
`default_nettype wire
